[rtl/core/dots_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dots_pkg: shared types for the deadline ordered timer set
// Word layouts, slot entry layout, controller/datapath command and status.
// ---------------------------------------------------------------------------
package dots_pkg;

	localparam int TIME_W    = 48;
	localparam int DELAY_W   = 20;
	localparam int TAG_W     = 8;
	localparam int FIRES_W   = 16;
	localparam int STAMP_W   = 32;
	localparam int SLOT_W    = 4;
	localparam int MAX_FIRES = 16;
	localparam int NFIRE_W   = $clog2(MAX_FIRES);

	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_SET   = 2'd1,
		FN_CLEAR = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		KD_FIRED   = 2'd0,
		KD_SET_OK  = 2'd1,
		KD_FULL    = 2'd2,
		KD_CLEARED = 2'd3
	} kind_t;

	typedef struct packed {
		func_t              func;
		logic [DELAY_W-1:0] delay_ms;
		logic               recurring;
		logic [TAG_W-1:0]   callback_tag;
	} item_t;

	typedef struct packed {
		kind_t              kind;
		logic [SLOT_W-1:0]  slot;
		logic [TAG_W-1:0]   tag;
		logic [FIRES_W-1:0] fire_total;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [TIME_W-1:0]  deadline;
		logic [DELAY_W-1:0] period;
		logic [TAG_W-1:0]   tag;
		logic [FIRES_W-1:0] fires;
		logic [STAMP_W-1:0] stamp;
	} ent_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_run;
		logic fire;
		logic flush;
		logic set_step;
		logic set_write;
		logic refuse;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic best_vld;
		logic fire_cap;
		logic pend_vld;
		logic out_free;
		logic free_hit;
		logic idx_last;
	} sts_t;

	// true when entry a must fire before entry b
	function automatic logic ent_earlier(ent_t a, ent_t b);
		logic [STAMP_W-1:0] diff;
		diff = a.stamp - b.stamp;
		if (a.deadline != b.deadline) begin
			return a.deadline < b.deadline;
		end
		return diff[STAMP_W-1];
	endfunction

endpackage
`default_nettype wire

[rtl/core/dots_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dots_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dots_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/dots_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dots_ctrl: sequencer of the timer set
// Walks one word through scan, fire, set lookup or clear steps.
// ---------------------------------------------------------------------------
module dots_ctrl
	import dots_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	input  wire func_t func,
	input  wire sts_t  sts,
	output logic       item_stall,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIRE,
		ST_FLUSH,
		ST_SET,
		ST_CLEAR
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_stall = (state_q != ST_IDLE);

	// decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					case (func)
						FN_TICK:  state_d = ST_SCAN;
						FN_SET:   state_d = ST_SET;
						FN_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_FIRE;
				end
			end
			ST_FIRE: begin
				if (!sts.best_vld) begin
					state_d = ST_FLUSH;
				end else if (!sts.pend_vld || sts.out_free) begin
					cmd.fire     = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d      = sts.fire_cap ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_vld) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_SET: begin
				if (sts.free_hit) begin
					if (sts.out_free) begin
						cmd.set_write = 1'b1;
						state_d       = ST_IDLE;
					end
				end else if (sts.idx_last) begin
					if (sts.out_free) begin
						cmd.refuse = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cmd.set_step = 1'b1;
				end
			end
			ST_CLEAR: begin
				if (sts.out_free) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/dots_dp.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dots_dp: datapath of the timer set
// Time and order counters, valid bits, slot RAM, earliest-due search,
// pending fire word and the output register.
// ---------------------------------------------------------------------------
module dots_dp
	import dots_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	input  wire item_t item,
	output sts_t       sts,
	output logic       res_valid,
	input  wire logic  res_stall,
	output res_t       res
);

	localparam int SW    = $clog2(NUM_SLOTS);
	localparam int IW    = SW + 1;
	localparam int ENT_W = $bits(ent_t);

	logic [TIME_W-1:0]  time_q;
	logic [STAMP_W-1:0] order_q;
	logic [NUM_SLOTS-1:0] valid_q;
	item_t              in_q;
	logic [IW-1:0]      idx_q;
	logic               chk_vld_s1;
	logic [SW-1:0]      chk_idx_s1;
	logic               best_vld_q;
	logic [SW-1:0]      best_idx_q;
	ent_t               best_q;
	logic               pend_vld_q;
	res_t               pend_q;
	logic [NFIRE_W-1:0] nfire_q;
	logic               out_vld_q;
	res_t               out_q;

	logic               re;
	logic               we;
	logic [SW-1:0]      waddr;
	ent_t               wr_ent;
	logic [ENT_W-1:0]   rdata;
	ent_t               rd_ent;
	ent_t               fire_ent;
	ent_t               set_ent;
	logic               take;
	logic               out_free;
	logic               out_push;
	res_t               out_d;
	res_t               fire_res;

	dots_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NUM_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_ent),
		.re   (re),
		.raddr(idx_q[SW-1:0]),
		.rdata(rdata)
	);

	assign rd_ent = ent_t'(rdata);

	// read one slot a cycle while scanning
	assign re = cmd.scan_run && (idx_q < IW'(NUM_SLOTS));

	// keep the earliest due slot seen so far
	assign take = chk_vld_s1 && valid_q[chk_idx_s1] && (rd_ent.deadline < time_q)
		&& (!best_vld_q || ent_earlier(rd_ent, best_q));

	// next entry for the chosen slot, new set entry and the fire result word
	always_comb begin
		fire_ent          = best_q;
		fire_ent.fires    = best_q.fires + FIRES_W'(1);
		fire_ent.deadline = best_q.deadline + TIME_W'(best_q.period);
		fire_ent.stamp    = order_q;

		set_ent.deadline  = time_q + TIME_W'(in_q.delay_ms);
		set_ent.period    = in_q.recurring ? in_q.delay_ms : '0;
		set_ent.tag       = in_q.callback_tag;
		set_ent.fires     = '0;
		set_ent.stamp     = order_q;

		fire_res.kind       = KD_FIRED;
		fire_res.slot       = SLOT_W'(best_idx_q);
		fire_res.tag        = best_q.tag;
		fire_res.fire_total = fire_ent.fires;
		fire_res.last       = 1'b0;
	end

	assign we     = cmd.fire || cmd.set_write;
	assign waddr  = cmd.fire ? best_idx_q : idx_q[SW-1:0];
	assign wr_ent = cmd.fire ? fire_ent : set_ent;

	// select the word to push into the output register
	always_comb begin
		out_push = 1'b0;
		out_d    = pend_q;
		if (cmd.fire && pend_vld_q) begin
			out_push   = 1'b1;
			out_d.last = 1'b0;
		end else if (cmd.flush) begin
			out_push   = 1'b1;
			out_d.last = 1'b1;
		end else if (cmd.set_write) begin
			out_push         = 1'b1;
			out_d.kind       = KD_SET_OK;
			out_d.slot       = SLOT_W'(idx_q[SW-1:0]);
			out_d.tag        = in_q.callback_tag;
			out_d.fire_total = '0;
			out_d.last       = 1'b1;
		end else if (cmd.refuse) begin
			out_push         = 1'b1;
			out_d.kind       = KD_FULL;
			out_d.slot       = '0;
			out_d.tag        = in_q.callback_tag;
			out_d.fire_total = '0;
			out_d.last       = 1'b1;
		end else if (cmd.clear) begin
			out_push         = 1'b1;
			out_d.kind       = KD_CLEARED;
			out_d.slot       = '0;
			out_d.tag        = '0;
			out_d.fire_total = '0;
			out_d.last       = 1'b1;
		end
	end

	assign out_free = !out_vld_q || !res_stall;

	// report status
	always_comb begin
		sts.scan_done = chk_vld_s1 && (chk_idx_s1 == SW'(NUM_SLOTS - 1));
		sts.best_vld  = best_vld_q;
		sts.fire_cap  = (nfire_q == NFIRE_W'(MAX_FIRES - 1));
		sts.pend_vld  = pend_vld_q;
		sts.out_free  = out_free;
		sts.free_hit  = !valid_q[idx_q[SW-1:0]];
		sts.idx_last  = (idx_q == IW'(NUM_SLOTS - 1));
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q     <= '0;
			order_q    <= '0;
			valid_q    <= '0;
			idx_q      <= '0;
			chk_vld_s1 <= 1'b0;
			best_vld_q <= 1'b0;
			pend_vld_q <= 1'b0;
			nfire_q    <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (item.func == FN_TICK) begin
					time_q <= time_q + TIME_W'(1);
				end
				idx_q      <= '0;
				chk_vld_s1 <= 1'b0;
				best_vld_q <= 1'b0;
				nfire_q    <= '0;
			end
			if (cmd.scan_clr) begin
				idx_q      <= '0;
				chk_vld_s1 <= 1'b0;
				best_vld_q <= 1'b0;
			end
			if (cmd.scan_run) begin
				chk_vld_s1 <= re;
				if (re) begin
					idx_q <= idx_q + IW'(1);
				end
				if (take) begin
					best_vld_q <= 1'b1;
				end
			end
			if (cmd.fire) begin
				if (best_q.period == '0) begin
					valid_q[best_idx_q] <= 1'b0;
				end else begin
					order_q <= order_q + STAMP_W'(1);
				end
				nfire_q    <= nfire_q + NFIRE_W'(1);
				pend_vld_q <= 1'b1;
			end
			if (cmd.flush) begin
				pend_vld_q <= 1'b0;
			end
			if (cmd.set_step) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.set_write) begin
				valid_q[idx_q[SW-1:0]] <= 1'b1;
				order_q                <= order_q + STAMP_W'(1);
			end
			if (cmd.clear) begin
				valid_q <= '0;
			end
			if (out_push) begin
				out_vld_q <= 1'b1;
			end else if (!res_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= item;
		end
		if (re) begin
			chk_idx_s1 <= idx_q[SW-1:0];
		end
		if (cmd.scan_run && take) begin
			best_q     <= rd_ent;
			best_idx_q <= chk_idx_s1;
		end
		if (cmd.fire) begin
			pend_q <= fire_res;
		end
		if (out_push) begin
			out_q <= out_d;
		end
	end

	assign res_valid = out_vld_q;
	assign res       = out_q;

endmodule
`default_nettype wire

[rtl/core/deadline_ordered_timer_set.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// deadline_ordered_timer_set: table of one-shot and periodic ms timers
// Controller and datapath around a slot RAM, searched once per firing.
// ---------------------------------------------------------------------------
// Input channel item_valid/item_stall/item carries tick, set and clear words;
// output channel res_valid/res_stall/res carries result words, the final
// word of each input marked with last.
// One input word is worked at a time; item_stall is high from acceptance
// until its last result sits in the output register.
// Tick: each firing costs a search over the slot RAM, at most 16 firings per
// tick; a tick with nothing due gives no word. Set: free slot lookup walks
// the valid bits one a cycle.
// A stalled output register holds its word; the sequencer waits only when
// it must push another word into the full register.
// Reset clears time, order counter, valid bits and all control state; slot
// RAM contents are only used for valid slots and need no clearing.
// ---------------------------------------------------------------------------
module deadline_ordered_timer_set
	import dots_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       res_valid,
	input  wire logic  res_stall,
	output res_t       res
);

	cmd_t cmd;
	sts_t sts;

	dots_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.func      (item.func),
		.sts       (sts),
		.item_stall(item_stall),
		.cmd       (cmd)
	);

	dots_dp #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.sts      (sts),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule
`default_nettype wire

[rtl/core/dots_chk.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dots_chk: port checks of the timer set
// Watches the top level ports and flags word sequencing errors.
// ---------------------------------------------------------------------------
module dots_chk
	import dots_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  item_valid,
	input wire logic  item_stall,
	input wire item_t item,
	input wire logic  res_valid,
	input wire logic  res_stall,
	input wire res_t  res
);

	// a working word blocks the input on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.func == FN_TICK || item.func == FN_SET
			|| item.func == FN_CLEAR) |=> item_stall)
		else $error("input not stalled after accepting a word");

	// clear answers with one plain word
	a_clear_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KD_CLEARED |-> res.last && res.slot == '0
			&& res.tag == '0 && res.fire_total == '0)
		else $error("malformed clear word");

	// set answers are single words with zero count
	a_set_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KD_SET_OK || res.kind == KD_FULL)
			|-> res.last && res.fire_total == '0)
		else $error("malformed set word");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

endmodule

bind deadline_ordered_timer_set dots_chk u_dots_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_stall(item_stall),
	.item      (item),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
`default_nettype wire

[tb/deadline_ordered_timer_set_test.sv]
// ---------------------------------------------------------------------------
// deadline_ordered_timer_set_test: self-checking bench for the timer set
// Drives tick, set and clear words through the valid/stall input channel,
// predicts every result word from a behavioral copy of the slot table and
// compares the output channel word by word, with random gaps on both sides.
// ---------------------------------------------------------------------------
module deadline_ordered_timer_set_test;
	import dots_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS = 16;
	localparam int RANDOM_WORDS = 400;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_OFF = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [1:0] FN_UNUSED = 2'd3;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_stall;
	item_t item = '0;
	logic  res_valid;
	logic  res_stall = 1'b1;
	res_t  res;

	deadline_ordered_timer_set #(.NUM_SLOTS(NUM_SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #5 clk = ~clk;

	// timer table mirror
	logic [TIME_W-1:0]  now_ms;
	logic [STAMP_W-1:0] order_ctr;
	logic               slot_on [NUM_SLOTS];
	logic [TIME_W-1:0]  due_at [NUM_SLOTS];
	logic [DELAY_W-1:0] reload [NUM_SLOTS];
	logic [TAG_W-1:0]   slot_tag [NUM_SLOTS];
	logic [FIRES_W-1:0] fire_cnt [NUM_SLOTS];
	logic [STAMP_W-1:0] stamp [NUM_SLOTS];

	res_t pending_words[$];
	int   errors = 0;
	int   idle_cycles = 0;
	int   words_seen = 0;
	int   fired_seen = 0;
	int   full_seen = 0;
	int   ticks_sent = 0;
	int   sets_sent = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;

	function automatic logic fires_before(int a, int b);
		logic [STAMP_W-1:0] diff;
		diff = stamp[a] - stamp[b];
		if (due_at[a] != due_at[b]) begin
			return due_at[a] < due_at[b];
		end
		return diff[STAMP_W-1];
	endfunction

	// advance the mirror by one word and queue the words it must produce
	task automatic predict_timers(item_t w);
		int   best;
		int   n;
		int   free_slot;
		res_t r;
		n = 0;
		case (w.func)
			FN_TICK: begin
				now_ms = now_ms + 1'b1;
				while (n < MAX_FIRES) begin
					best = -1;
					for (int s = 0; s < NUM_SLOTS; s++) begin
						if (slot_on[s] && due_at[s] < now_ms && (best < 0 || fires_before(s, best)))
							best = s;
					end
					if (best < 0) break;
					fire_cnt[best] = fire_cnt[best] + 1'b1;
					r = '{KD_FIRED, best[SLOT_W-1:0], slot_tag[best], fire_cnt[best], 1'b0};
					pending_words.push_back(r);
					n++;
					if (reload[best] != '0) begin
						due_at[best] = due_at[best] + reload[best];
						stamp[best] = order_ctr;
						order_ctr = order_ctr + 1'b1;
					end else begin
						slot_on[best] = 1'b0;
					end
				end
			end
			FN_SET: begin
				free_slot = -1;
				for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
					if (!slot_on[s]) free_slot = s;
				end
				if (free_slot < 0) begin
					r = '{KD_FULL, '0, w.callback_tag, '0, 1'b0};
				end else begin
					slot_on[free_slot] = 1'b1;
					due_at[free_slot] = now_ms + w.delay_ms;
					reload[free_slot] = w.recurring ? w.delay_ms : '0;
					slot_tag[free_slot] = w.callback_tag;
					fire_cnt[free_slot] = '0;
					stamp[free_slot] = order_ctr;
					order_ctr = order_ctr + 1'b1;
					r = '{KD_SET_OK, free_slot[SLOT_W-1:0], w.callback_tag, '0, 1'b0};
				end
				pending_words.push_back(r);
				n = 1;
			end
			FN_CLEAR: begin
				for (int s = 0; s < NUM_SLOTS; s++) slot_on[s] = 1'b0;
				r = '{KD_CLEARED, '0, '0, '0, 1'b0};
				pending_words.push_back(r);
				n = 1;
			end
			default: ;
		endcase
		// mark the final word of this input
		if (n > 0) begin
			r = pending_words.pop_back();
			r.last = 1'b1;
			pending_words.push_back(r);
		end
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("MISMATCH %s at word %0d: got %0h want %0h", what, words_seen, got, want);
	endtask

	// check each accepted result word against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_words.size() == 0) begin
				report("unexpected word", res, 0);
			end else begin
				want = pending_words.pop_front();
				if (res.kind != want.kind) report("kind", res.kind, want.kind);
				if (res.slot != want.slot) report("slot", res.slot, want.slot);
				if (res.tag != want.tag) report("tag", res.tag, want.tag);
				if (res.fire_total != want.fire_total)
					report("fire_total", res.fire_total, want.fire_total);
				if (res.last != want.last) report("last", res.last, want.last);
				if (want.kind == KD_FIRED) fired_seen++;
				if (want.kind == KD_FULL) full_seen++;
			end
			words_seen++;
		end
	end

	// drive the receiver stall: one long hold-off, otherwise random gaps
	always @(posedge clk) begin
		int roll;
		roll = $urandom_range(99);
		if (!arst_n) begin
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (!hold_done && words_seen >= 120) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_OFF;
			res_stall <= 1'b1;
		end else if (words_seen % 200 > 150) begin
			res_stall <= 1'b0;
		end else if (roll < 65) begin
			res_stall <= 1'b0;
		end else if (roll < 97) begin
			res_stall <= 1'b1;
		end else begin
			hold_left <= $urandom_range(40, 10);
			res_stall <= 1'b1;
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("deadline_ordered_timer_set verification failed");
				$finish;
			end
		end
	end

	// offer one word and hold it until accepted, then idle a random gap
	task automatic send_word(item_t w, bit typed, res_t typed_word);
		int gap;
		int roll;
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (!(item_valid && !item_stall));
		if (w.func == FN_TICK) ticks_sent++;
		if (w.func == FN_SET) sets_sent++;
		predict_timers(w);
		// swap in the hand-written expectation where one is given
		if (typed) begin
			void'(pending_words.pop_back());
			pending_words.push_back(typed_word);
		end
		roll = $urandom_range(99);
		gap = (ticks_sent % 100 > 70) ? 0 : (roll < 65) ? 0 : (roll < 95) ?
			$urandom_range(3, 1) : $urandom_range(40, 10);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	typedef struct {
		logic [1:0]         func;
		logic [DELAY_W-1:0] delay_ms;
		logic               recurring;
		logic [TAG_W-1:0]   tag;
		int                 reps;
		bit                 typed;
		res_t               want;
	} plan_row_t;

	plan_row_t plan[16];

	function automatic item_t random_word();
		item_t w;
		int    roll;
		roll = $urandom_range(99);
		w.func = (roll < 50) ? FN_TICK : (roll < 93) ? FN_SET : (roll < 97) ? FN_CLEAR :
			func_t'(FN_UNUSED);
		roll = $urandom_range(99);
		w.delay_ms = (roll < 80) ? DELAY_W'($urandom_range(12)) :
			(roll < 92) ? DELAY_W'($urandom_range(60)) : DELAY_W'($urandom);
		w.recurring = 1'($urandom_range(1));
		w.callback_tag = TAG_W'($urandom_range(255));
		return w;
	endfunction

	initial begin
		item_t w;
		int    sent;
		now_ms = '0;
		order_ctr = '0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			slot_on[s] = 1'b0;
			due_at[s] = '0;
			reload[s] = '0;
			slot_tag[s] = '0;
			fire_cnt[s] = '0;
			stamp[s] = '0;
		end

		// extremes, every code, full table and a sixteen-firing tick
		plan[0]  = '{FN_SET, 20'd0, 1'b1, 8'hFF, 1, 1, '{KD_SET_OK, 4'd0, 8'hFF, 16'd0, 1'b1}};
		plan[1]  = '{FN_SET, 20'hFFFFF, 1'b1, 8'h00, 1, 1,
			'{KD_SET_OK, 4'd1, 8'h00, 16'd0, 1'b1}};
		plan[2]  = '{FN_SET, 20'd1, 1'b0, 8'h5A, 1, 1, '{KD_SET_OK, 4'd2, 8'h5A, 16'd0, 1'b1}};
		plan[3]  = '{FN_SET, 20'd2, 1'b1, 8'hA5, 1, 1, '{KD_SET_OK, 4'd3, 8'hA5, 16'd0, 1'b1}};
		plan[4]  = '{FN_TICK, 20'd0, 1'b0, 8'h00, 7, 0, '0};
		plan[5]  = '{FN_UNUSED, 20'hFFFFF, 1'b1, 8'hFF, 1, 0, '0};
		plan[6]  = '{FN_CLEAR, 20'd0, 1'b0, 8'h00, 1, 1,
			'{KD_CLEARED, 4'd0, 8'h00, 16'd0, 1'b1}};
		plan[7]  = '{FN_SET, 20'd0, 1'b0, 8'h10, 16, 0, '0};
		plan[8]  = '{FN_SET, 20'd7, 1'b1, 8'hAA, 1, 1, '{KD_FULL, 4'd0, 8'hAA, 16'd0, 1'b1}};
		plan[9]  = '{FN_TICK, 20'd0, 1'b0, 8'h00, 1, 0, '0};
		plan[10] = '{FN_SET, 20'd3, 1'b1, 8'h20, 16, 0, '0};
		plan[11] = '{FN_TICK, 20'd0, 1'b0, 8'h00, 9, 0, '0};
		plan[12] = '{FN_CLEAR, 20'd0, 1'b0, 8'h00, 1, 0, '0};
		plan[13] = '{FN_SET, 20'd1, 1'b1, 8'h33, 1, 0, '0};
		plan[14] = '{FN_SET, 20'd1, 1'b0, 8'h44, 1, 0, '0};
		plan[15] = '{FN_TICK, 20'd0, 1'b0, 8'h00, 4, 0, '0};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].reps; k++) begin
				w.func = func_t'(plan[i].func);
				w.delay_ms = plan[i].delay_ms;
				w.recurring = plan[i].recurring;
				w.callback_tag = TAG_W'(plan[i].tag + k);
				send_word(w, plan[i].typed, plan[i].want);
			end
		end

		// random traffic, one full drain part way through
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			w = random_word();
			send_word(w, 1'b0, '0);
			if (w.func != FN_UNUSED) sent++;
			if (sent == RANDOM_WORDS / 2) begin
				item_valid <= 1'b0;
				wait (pending_words.size() == 0);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
		end
		item_valid <= 1'b0;

		wait (pending_words.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d ticks and %0d sets; checked %0d words, %0d firings, %0d refusals",
			ticks_sent, sets_sent, words_seen, fired_seen, full_seen);
		if (errors == 0) begin
			$display("deadline_ordered_timer_set verification clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("deadline_ordered_timer_set verification failed");
		end
		$finish;
	end

endmodule
